FILE: hdl/i2cseq_pkg.sv
// Package for the I2C master register transfer sequencer.
// Holds the event kinds, sequencer phases and the packed stream payload layouts.
// No dependencies; the top level imports it.
package i2cseq_pkg;

   localparam int unsigned KIND_W     = 2;
   localparam int unsigned INDEX_W    = 5;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned COUNT_W    = 6;
   localparam int unsigned SLOT_W     = 5;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD     = 2'd0,
      KIND_START    = 2'd1,
      KIND_TX_READY = 2'd2,
      KIND_RX_BYTE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SEND_ADDR = 3'd1,
      PH_TO_RX     = 3'd2,
      PH_RX_DATA   = 3'd3,
      PH_TX_DATA   = 3'd4
   } phase_type;

   // Request payload; the last member sits in the lowest bits.
   typedef struct packed {
      logic [6:0]         pad;
      logic [COUNT_W-1:0] write_count;
      logic [COUNT_W-1:0] read_count;
      logic [BYTE_W-1:0]  reg_address;
      logic [BYTE_W-1:0]  data_byte;
      logic [INDEX_W-1:0] buffer_index;
   } req_data_type;

   // Response payload; the last member sits in the lowest bits.
   typedef struct packed {
      logic [4:0]        pad;
      logic              busy_res;
      logic              done_res;
      logic [SLOT_W-1:0] rx_slot;
      logic [BYTE_W-1:0] rx_byte;
      logic              rx_valid;
      logic              send_stop;
      logic              restart_read;
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_valid;
   } rsp_data_type;

endpackage

FILE: hdl/i2cseq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the transmit byte buffer of the sequencer. No dependencies.
module i2cseq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/i2c_master_register_transfer_sequencer_core.sv
// Top level of the I2C master register transfer sequencer.
// Depends on i2cseq_pkg and on i2cseq_ram for the transmit buffer.
//
// Usage: each request transaction carries one controller event, with its kind in
// req_tuser (load byte, start, transmitter ready, byte received) and its fields in
// req_tdata. Every request produces exactly one response transaction on rsp_*,
// telling the controller what to do: hand over a byte, issue a repeated start,
// request a stop, or deliver a received byte with its slot, plus done and busy.
//
// A request passes through the input register, then the sequencer logic loads the
// response register. A new request is taken in every cycle while the response is
// not stalled; throughput is one transaction per clock, set by the single update of
// the phase and counter registers per event. The transmit buffer is a RAM read ahead
// at the next write position, with a bypass for a load to that slot.
//
// Reset (synchronous, active high) returns the sequencer to idle and empties both
// pipeline registers; the buffer contents are undefined until loaded. When the
// receiver stalls rsp_tready, the response holds and one more request can wait in
// the input register before req_tready drops.
module i2c_master_register_transfer_sequencer_core #(
   parameter int unsigned BUFFER_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // From bit 0: buffer_index[4:0], data_byte[7:0], reg_address[7:0],
   // read_count[5:0], write_count[5:0], zero fill to 40 bits.
   input  logic [i2cseq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // From bit 0: kind[1:0].
   input  logic [i2cseq_pkg::KIND_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // From bit 0: tx_valid, tx_byte[7:0], restart_read, send_stop, rx_valid,
   // rx_byte[7:0], rx_slot[4:0], done_res, busy_res, zero fill to 32 bits.
   output logic [i2cseq_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import i2cseq_pkg::*;

   localparam int unsigned ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int unsigned COUNT_MAX = (2 ** COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (BUFFER_DEPTH > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(BUFFER_DEPTH);

   // Input register.
   logic         in_valid_ff, in_valid_in;
   kind_type     in_kind_ff;
   req_data_type in_data_ff;

   // Response register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   // Sequencer state.
   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  addr_ff, addr_in;
   logic [COUNT_W-1:0] reads_left_ff, reads_left_in;
   logic [COUNT_W-1:0] writes_left_ff, writes_left_in;
   logic [COUNT_W-1:0] write_pos_ff, write_pos_in;
   logic [SLOT_W-1:0]  read_pos_ff, read_pos_in;

   // Buffer access and load bypass.
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data, store_byte;
   logic              byp_hit_ff, byp_hit_in;
   logic [BYTE_W-1:0] byp_data_ff;

   logic               advance;
   logic               load_in_range;
   logic [COUNT_W-1:0] reads_dec;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign load_in_range = 32'(in_data_ff.buffer_index) < BUFFER_DEPTH;
   assign ram_wr_addr   = ADDR_W'(in_data_ff.buffer_index);
   // Read ahead at the position the next event will send from.
   assign ram_rd_addr   = ADDR_W'(write_pos_in);
   assign byp_hit_in    = ram_wr_en && (ram_wr_addr == ram_rd_addr);
   assign store_byte    = byp_hit_ff ? byp_data_ff : ram_rd_data;
   assign reads_dec     = reads_left_ff - COUNT_W'(1);

   i2cseq_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_tx_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(in_data_ff.data_byte),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      phase_in       = phase_ff;
      addr_in        = addr_ff;
      reads_left_in  = reads_left_ff;
      writes_left_in = writes_left_ff;
      write_pos_in   = write_pos_ff;
      read_pos_in    = read_pos_ff;
      ram_wr_en      = 1'b0;
      rsp_data_in    = '0;
      if (advance) begin
         unique case (in_kind_ff)
            KIND_LOAD: begin
               ram_wr_en = load_in_range;
            end
            KIND_START: begin
               addr_in = in_data_ff.reg_address;
               reads_left_in = (in_data_ff.read_count > COUNT_CAP) ?
                               COUNT_CAP : in_data_ff.read_count;
               writes_left_in = (in_data_ff.write_count > COUNT_CAP) ?
                                COUNT_CAP : in_data_ff.write_count;
               read_pos_in  = '0;
               write_pos_in = '0;
               phase_in     = PH_SEND_ADDR;
            end
            KIND_TX_READY: begin
               unique case (phase_ff)
                  PH_SEND_ADDR: begin
                     rsp_data_in.tx_valid = 1'b1;
                     rsp_data_in.tx_byte  = addr_ff;
                     phase_in = (reads_left_ff != '0) ? PH_TO_RX : PH_TX_DATA;
                  end
                  PH_TO_RX: begin
                     rsp_data_in.restart_read = 1'b1;
                     rsp_data_in.send_stop    = (reads_left_ff == COUNT_W'(1));
                     phase_in = PH_RX_DATA;
                  end
                  PH_TX_DATA: begin
                     if (writes_left_ff != '0) begin
                        rsp_data_in.tx_valid = 1'b1;
                        rsp_data_in.tx_byte  = store_byte;
                        write_pos_in   = write_pos_ff + COUNT_W'(1);
                        writes_left_in = writes_left_ff - COUNT_W'(1);
                     end else begin
                        rsp_data_in.send_stop = 1'b1;
                        rsp_data_in.done_res  = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            KIND_RX_BYTE: begin
               if (phase_ff == PH_RX_DATA) begin
                  if (reads_left_ff != '0) begin
                     rsp_data_in.rx_valid = 1'b1;
                     rsp_data_in.rx_byte  = in_data_ff.data_byte;
                     rsp_data_in.rx_slot  = read_pos_ff;
                     read_pos_in   = read_pos_ff + SLOT_W'(1);
                     reads_left_in = reads_dec;
                  end
                  // Stop goes out with the second-to-last byte; done goes out with the last.
                  if (reads_left_in == COUNT_W'(1)) begin
                     rsp_data_in.send_stop = 1'b1;
                  end else if (reads_left_in == '0) begin
                     rsp_data_in.done_res = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      rsp_data_in.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         addr_ff        <= '0;
         reads_left_ff  <= '0;
         writes_left_ff <= '0;
         write_pos_ff   <= '0;
         read_pos_ff    <= '0;
         byp_hit_ff     <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         phase_ff       <= phase_in;
         addr_ff        <= addr_in;
         reads_left_ff  <= reads_left_in;
         writes_left_ff <= writes_left_in;
         write_pos_ff   <= write_pos_in;
         read_pos_ff    <= read_pos_in;
         byp_hit_ff     <= byp_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= kind_type'(req_tuser);
         in_data_ff <= req_data_type'(req_tdata);
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
      byp_data_ff <= in_data_ff.data_byte;
   end

`ifndef SYNTHESIS
   // The busy flag of a response reflects the phase that its event left behind.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_data_ff.busy_res == (phase_ff != PH_IDLE)))
      else $error("busy_res disagrees with the sequencer phase");

   // A response never hands a byte to the transmitter and delivers one at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.tx_valid && rsp_data_ff.rx_valid))
      else $error("transmit and receive reported in the same response");

   // A ready event after the address of a read always moves into receive.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_kind_ff == KIND_TX_READY && phase_ff == PH_TO_RX)
      |=> (phase_ff == PH_RX_DATA && rsp_data_ff.restart_read))
      else $error("repeated start did not enter the receive phase");

   // Saturated counts never exceed the buffer depth.
   assert property (@(posedge clock) disable iff (reset)
      (reads_left_ff <= COUNT_CAP) && (writes_left_ff <= COUNT_CAP))
      else $error("transfer count above the buffer depth");
`endif

endmodule
